[src/ifmt_pkg.sv]
package ifmt_pkg;

  localparam int MAX_FIELD_DEF = 63;
  localparam int VALUE_W       = 64;
  localparam int FIELD_W       = 6;
  localparam int RSEL_W        = 2;
  localparam int CHAR_W        = 8;
  localparam int NDIG          = 22;
  localparam int DIG_IDX_W     = $clog2(NDIG);
  localparam int BCD_DIGITS    = 20;
  localparam int STEP_W        = 4;

  localparam logic [RSEL_W-1:0] RSEL_OCT = 2'd1;
  localparam logic [RSEL_W-1:0] RSEL_HEX = 2'd2;

  localparam logic [DIG_IDX_W-1:0] TOP_DEC = 5'd19;
  localparam logic [DIG_IDX_W-1:0] TOP_OCT = 5'd21;
  localparam logic [DIG_IDX_W-1:0] TOP_HEX = 5'd15;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_WAIT,
    ACT_DAB_INIT,
    ACT_DABBLE,
    ACT_SCAN_INIT,
    ACT_SCAN,
    ACT_SIZE,
    ACT_LOAD_PAD,
    ACT_LOAD_LEN,
    ACT_EMIT_SPACE,
    ACT_EMIT_SIGN,
    ACT_EMIT_ZERO,
    ACT_EMIT_DIGIT
  } act_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_DEC,
    COND_NO_LEAD,
    COND_NO_SIGN,
    COND_NO_ZPAD,
    COND_NO_TRAIL
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT       = 4'd0;
  localparam step_t ST_DAB_INIT   = 4'd1;
  localparam step_t ST_DABBLE     = 4'd2;
  localparam step_t ST_SCAN_INIT  = 4'd3;
  localparam step_t ST_SCAN       = 4'd4;
  localparam step_t ST_SIZE       = 4'd5;
  localparam step_t ST_LOAD_LEAD  = 4'd6;
  localparam step_t ST_LEAD       = 4'd7;
  localparam step_t ST_SIGN       = 4'd8;
  localparam step_t ST_LOAD_ZPAD  = 4'd9;
  localparam step_t ST_ZPAD       = 4'd10;
  localparam step_t ST_LOAD_DIGS  = 4'd11;
  localparam step_t ST_DIGS       = 4'd12;
  localparam step_t ST_LOAD_TRAIL = 4'd13;
  localparam step_t ST_TRAIL      = 4'd14;
  localparam step_t ST_DONE       = 4'd15;

  // one control word: action, skip condition, skip target
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    act_e act;
    logic run;
  } ctrl_t;

  typedef struct packed {
    logic done;
    logic not_dec;
    logic no_lead;
    logic no_sign;
    logic no_zpad;
    logic no_trail;
    logic rem_zero;
  } stat_t;

  function automatic uword_t ucode(step_t pc);
    uword_t w;
    case (pc)
      ST_WAIT:       w = '{ACT_WAIT,       COND_NEVER,    ST_WAIT};
      ST_DAB_INIT:   w = '{ACT_DAB_INIT,   COND_NOT_DEC,  ST_SCAN_INIT};
      ST_DABBLE:     w = '{ACT_DABBLE,     COND_NEVER,    ST_WAIT};
      ST_SCAN_INIT:  w = '{ACT_SCAN_INIT,  COND_NEVER,    ST_WAIT};
      ST_SCAN:       w = '{ACT_SCAN,       COND_NEVER,    ST_WAIT};
      ST_SIZE:       w = '{ACT_SIZE,       COND_NEVER,    ST_WAIT};
      ST_LOAD_LEAD:  w = '{ACT_LOAD_PAD,   COND_NEVER,    ST_WAIT};
      ST_LEAD:       w = '{ACT_EMIT_SPACE, COND_NO_LEAD,  ST_SIGN};
      ST_SIGN:       w = '{ACT_EMIT_SIGN,  COND_NO_SIGN,  ST_LOAD_ZPAD};
      ST_LOAD_ZPAD:  w = '{ACT_LOAD_PAD,   COND_NEVER,    ST_WAIT};
      ST_ZPAD:       w = '{ACT_EMIT_ZERO,  COND_NO_ZPAD,  ST_LOAD_DIGS};
      ST_LOAD_DIGS:  w = '{ACT_LOAD_LEN,   COND_NEVER,    ST_WAIT};
      ST_DIGS:       w = '{ACT_EMIT_DIGIT, COND_NEVER,    ST_WAIT};
      ST_LOAD_TRAIL: w = '{ACT_LOAD_PAD,   COND_NEVER,    ST_WAIT};
      ST_TRAIL:      w = '{ACT_EMIT_SPACE, COND_NO_TRAIL, ST_DONE};
      ST_DONE:       w = '{ACT_NOP,        COND_ALWAYS,   ST_WAIT};
      default:       w = '{ACT_NOP,        COND_ALWAYS,   ST_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0000, d};
    end else begin
      c = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[src/ifmt_in_if.sv]
interface ifmt_in_if;
  import ifmt_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_signed;
  logic [RSEL_W-1:0]  radix_select;
  logic               upper_digits;
  logic               pad_zero;
  logic               left_justify;
  logic               force_plus;
  logic               blank_sign;
  logic [FIELD_W-1:0] min_width;
  logic [FIELD_W-1:0] min_digits;

  modport source (
    output valid, value, is_signed, radix_select, upper_digits, pad_zero,
           left_justify, force_plus, blank_sign, min_width, min_digits,
    input  ready
  );

  modport sink (
    input  valid, value, is_signed, radix_select, upper_digits, pad_zero,
           left_justify, force_plus, blank_sign, min_width, min_digits,
    output ready
  );
endinterface

[src/ifmt_out_if.sv]
interface ifmt_out_if;
  import ifmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_last;

  modport source (
    output valid, out_char, is_last,
    input  ready
  );

  modport sink (
    input  valid, out_char, is_last,
    output ready
  );
endinterface

[src/ifmt_seq.sv]
module ifmt_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifmt_pkg::stat_t stat_i,
  output ifmt_pkg::ctrl_t ctrl_o
);
  import ifmt_pkg::*;

  step_t  pc_q;
  step_t  pc_d;
  uword_t uw;
  logic   skip;

  assign uw = ucode(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEVER:    skip = 1'b0;
      COND_ALWAYS:   skip = 1'b1;
      COND_NOT_DEC:  skip = stat_i.not_dec;
      COND_NO_LEAD:  skip = stat_i.no_lead;
      COND_NO_SIGN:  skip = stat_i.no_sign;
      COND_NO_ZPAD:  skip = stat_i.no_zpad;
      COND_NO_TRAIL: skip = stat_i.no_trail;
      default:       skip = 1'b0;
    endcase
  end

  always_comb begin
    ctrl_o.act = uw.act;
    ctrl_o.run = !skip;
  end

  always_comb begin
    pc_d = pc_q;
    if (skip) begin
      pc_d = uw.target;
    end else if (stat_i.done) begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end
endmodule

[src/ifmt_dp.sv]
module ifmt_dp #(
  parameter int MAX_FIELD = ifmt_pkg::MAX_FIELD_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifmt_pkg::ctrl_t ctrl_i,
  output ifmt_pkg::stat_t stat_o,
  ifmt_in_if.sink         in_i,
  ifmt_out_if.source      out_o
);
  import ifmt_pkg::*;

  localparam int CNT_A = $clog2(VALUE_W + 1);
  localparam int CNT_B = $clog2(MAX_FIELD + 2);
  localparam int CNT_W = (CNT_A > CNT_B) ? CNT_A : CNT_B;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int DIG_W = 4 * NDIG;
  localparam int OCT_W = 3 * NDIG;
  localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(MAX_FIELD - 1);
  localparam logic [CNT_W-1:0] DAB_STEPS = CNT_W'(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  logic [VALUE_W-1:0]   mag_q;
  logic [BCD_W-1:0]     bcd_q;
  radix_e               radix_q;
  logic                 upper_q;
  logic                 zero_q;
  logic                 ljust_q;
  logic                 has_sign_q;
  logic [CHAR_W-1:0]    sign_char_q;
  logic [CNT_W-1:0]     width_q;
  logic [CNT_W-1:0]     prec_q;
  logic [DIG_IDX_W-1:0] top_q;
  logic [CNT_W-1:0]     len_q;
  logic [CNT_W-1:0]     pad_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     rem_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic                 out_last_q;

  logic                 neg;
  logic [VALUE_W-1:0]   mag_d;
  logic                 has_sign_d;
  logic [CHAR_W-1:0]    sign_char_d;
  radix_e               radix_d;
  logic [CNT_W-1:0]     w_ext;
  logic [CNT_W-1:0]     p_ext;
  logic [CNT_W-1:0]     width_d;
  logic [CNT_W-1:0]     prec_d;
  logic [BCD_W-1:0]     bcd_adj;
  logic [DIG_W-1:0]     bcd_ext;
  logic [DIG_W-1:0]     hex_ext;
  logic [OCT_W-1:0]     oct_ext;
  logic [3:0]           dig [NDIG];
  logic [CNT_W-1:0]     pos;
  logic [DIG_IDX_W-1:0] rd_idx;
  logic [3:0]           rd_dig;
  logic                 in_range;
  logic [CNT_W-1:0]     ndig;
  logic [CNT_W-1:0]     len_d;
  logic [CNT_W-1:0]     body;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     pad_d;
  logic [DIG_IDX_W-1:0] top_init;
  logic                 scan_more;
  logic                 emit_act;
  logic                 out_free;
  logic                 fire_in;
  logic                 fire_out;
  logic                 done;
  logic [CHAR_W-1:0]    char_d;

  // operand capture
  always_comb begin
    neg         = in_i.is_signed && in_i.value[VALUE_W-1];
    mag_d       = neg ? (VALUE_W'(0) - in_i.value) : in_i.value;
    has_sign_d  = in_i.is_signed && (neg || in_i.force_plus || in_i.blank_sign);
    if (neg) begin
      sign_char_d = CH_MINUS;
    end else if (in_i.force_plus) begin
      sign_char_d = CH_PLUS;
    end else begin
      sign_char_d = CH_SPACE;
    end
    case (in_i.radix_select)
      RSEL_OCT: radix_d = RADIX_OCT;
      RSEL_HEX: radix_d = RADIX_HEX;
      default:  radix_d = RADIX_DEC;
    endcase
    w_ext   = CNT_W'(in_i.min_width);
    p_ext   = CNT_W'(in_i.min_digits);
    width_d = (w_ext > LIMIT) ? LIMIT : w_ext;
    prec_d  = (p_ext > LIMIT) ? LIMIT : p_ext;
  end

  // add-3 correction ahead of each binary-to-bcd shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] > 4'd4) ? (bcd_q[4*k +: 4] + 4'd3)
                                                   : bcd_q[4*k +: 4];
    end
  end

  // digit slots, least significant first
  always_comb begin
    bcd_ext = DIG_W'(bcd_q);
    hex_ext = DIG_W'(mag_q);
    oct_ext = OCT_W'(mag_q);
    for (int k = 0; k < NDIG; k++) begin
      case (radix_q)
        RADIX_OCT: dig[k] = {1'b0, oct_ext[3*k +: 3]};
        RADIX_HEX: dig[k] = hex_ext[4*k +: 4];
        default:   dig[k] = bcd_ext[4*k +: 4];
      endcase
    end
  end

  always_comb begin
    pos      = cnt_q - CNT_ONE;
    in_range = pos <= CNT_W'(top_q);
    rd_idx   = (ctrl_i.act == ACT_SCAN) ? top_q : pos[DIG_IDX_W-1:0];
    rd_dig   = dig[rd_idx];
    case (radix_q)
      RADIX_OCT: top_init = TOP_OCT;
      RADIX_HEX: top_init = TOP_HEX;
      default:   top_init = TOP_DEC;
    endcase
    scan_more = (rd_dig == 4'd0) && (top_q != '0);
  end

  // field sizing
  always_comb begin
    ndig  = CNT_W'(top_q) + CNT_ONE;
    len_d = (ndig > prec_q) ? ndig : prec_q;
    body  = len_d + CNT_W'(has_sign_q);
    total = (body > width_q) ? body : width_q;
    pad_d = total - body;
  end

  always_comb begin
    emit_act = ctrl_i.act inside {ACT_EMIT_SPACE, ACT_EMIT_SIGN, ACT_EMIT_ZERO,
                                  ACT_EMIT_DIGIT};
    out_free = !out_valid_q || out_o.ready;
    fire_in  = ctrl_i.run && (ctrl_i.act == ACT_WAIT) && in_i.valid;
    fire_out = ctrl_i.run && emit_act && out_free;
    case (ctrl_i.act)
      ACT_EMIT_SPACE: char_d = CH_SPACE;
      ACT_EMIT_SIGN:  char_d = sign_char_q;
      ACT_EMIT_ZERO:  char_d = CH_ZERO;
      ACT_EMIT_DIGIT: char_d = in_range ? digit_char(rd_dig, upper_q) : CH_ZERO;
      default:        char_d = CH_SPACE;
    endcase
  end

  always_comb begin
    case (ctrl_i.act)
      ACT_WAIT:       done = in_i.valid;
      ACT_DABBLE:     done = (cnt_q == CNT_ONE);
      ACT_SCAN:       done = !scan_more;
      ACT_EMIT_SIGN:  done = out_free;
      ACT_EMIT_SPACE,
      ACT_EMIT_ZERO,
      ACT_EMIT_DIGIT: done = out_free && (cnt_q == CNT_ONE);
      default:        done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.run) begin
        case (ctrl_i.act)
          ACT_DAB_INIT:   cnt_q <= DAB_STEPS;
          ACT_DABBLE:     cnt_q <= cnt_q - CNT_ONE;
          ACT_LOAD_PAD:   cnt_q <= pad_q;
          ACT_LOAD_LEN:   cnt_q <= len_q;
          ACT_EMIT_SPACE,
          ACT_EMIT_ZERO,
          ACT_EMIT_DIGIT: if (out_free) cnt_q <= cnt_q - CNT_ONE;
          default:        cnt_q <= cnt_q;
        endcase
      end
      if (ctrl_i.run && (ctrl_i.act == ACT_SIZE)) begin
        rem_q <= total;
      end else if (fire_out) begin
        rem_q <= rem_q - CNT_ONE;
      end
      if (fire_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      mag_q       <= mag_d;
      radix_q     <= radix_d;
      upper_q     <= in_i.upper_digits;
      zero_q      <= in_i.pad_zero;
      ljust_q     <= in_i.left_justify;
      has_sign_q  <= has_sign_d;
      sign_char_q <= sign_char_d;
      width_q     <= width_d;
      prec_q      <= prec_d;
    end else if (ctrl_i.run && (ctrl_i.act == ACT_DABBLE)) begin
      mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
    end
    if (ctrl_i.run && (ctrl_i.act == ACT_DAB_INIT)) begin
      bcd_q <= '0;
    end else if (ctrl_i.run && (ctrl_i.act == ACT_DABBLE)) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
    end
    if (ctrl_i.run && (ctrl_i.act == ACT_SCAN_INIT)) begin
      top_q <= top_init;
    end else if (ctrl_i.run && (ctrl_i.act == ACT_SCAN) && scan_more) begin
      top_q <= top_q - 1'b1;
    end
    if (ctrl_i.run && (ctrl_i.act == ACT_SIZE)) begin
      len_q <= len_d;
      pad_q <= pad_d;
    end
    if (fire_out) begin
      out_char_q <= char_d;
      out_last_q <= (rem_q == CNT_ONE);
    end
  end

  assign in_i.ready     = ctrl_i.run && (ctrl_i.act == ACT_WAIT);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.is_last  = out_last_q;

  always_comb begin
    stat_o.done     = done;
    stat_o.not_dec  = (radix_q != RADIX_DEC);
    stat_o.no_lead  = zero_q || ljust_q || (pad_q == '0);
    stat_o.no_sign  = !has_sign_q;
    stat_o.no_zpad  = !zero_q || ljust_q || (pad_q == '0);
    stat_o.no_trail = !ljust_q || (pad_q == '0);
    stat_o.rem_zero = (rem_q == '0);
  end
endmodule

[src/integer_field_formatter_core.sv]
// channel | role   | payload
// in_i    | sink   | value, is_signed, radix_select, upper_digits, pad_zero, left_justify,
//         |        | force_plus, blank_sign, min_width, min_digits
// out_o   | source | out_char, is_last (one transfer per character)
//
// one item at a time: accept, then for decimal only the binary to bcd shift of all 64 bits,
// a scan past leading zero digit slots (up to 21), the fixed sequencer steps,
// one step per empty field section (two to four), and one character per cycle
// while the sink keeps ready high; the microcode step counter and the single shift
// unit set this pace
// asynchronous active-low reset returns the sequencer to the wait step with no output pending
// a stalled sink holds the output register and the character sequencer
module integer_field_formatter_core #(
  parameter int MAX_FIELD = ifmt_pkg::MAX_FIELD_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  ifmt_in_if.sink    in_i,
  ifmt_out_if.source out_o
);
  import ifmt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ifmt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  ifmt_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // every character of the previous field has been loaded into the output register before a new item is taken
  a_idle_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> stat.rem_zero)
    else $error("new item accepted with characters still owed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready straight after a transfer");

  a_dabble_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.run && ctrl.act == ACT_DABBLE) |-> !stat.not_dec)
    else $error("bcd shift running for a non-decimal radix");
endmodule

[tb/integer_field_formatter_core_test.sv]
module integer_field_formatter_core_test;
  import ifmt_pkg::*;

  localparam int FIELD_LIMIT = MAX_FIELD_DEF - 1;
  localparam int N_RANDOM    = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [RSEL_W-1:0] RSEL_SPARE = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
    logic [RSEL_W-1:0]  radix_select;
    logic               upper_digits;
    logic               pad_zero;
    logic               left_justify;
    logic               force_plus;
    logic               blank_sign;
    logic [FIELD_W-1:0] min_width;
    logic [FIELD_W-1:0] min_digits;
  } fmt_item_t;

  typedef struct packed {
    fmt_item_t item;
    logic      drain;
  } send_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              is_last;
  } fmt_char_t;

  logic clk_i;
  logic rst_ni;

  ifmt_in_if  in_if ();
  ifmt_out_if out_if ();

  integer_field_formatter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  send_t       send_q[$];
  fmt_char_t   field_chars_q[$];
  send_t       nxt;
  fmt_char_t   want;
  fmt_item_t   got;
  int          sent_cnt;
  int          acc_cnt;
  int          errors;
  int          idle_cycles;
  int unsigned tx_gap;
  int unsigned rx_gap;
  bit          tx_quiet;
  bit          rx_quiet;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected text of one field, pushed one character at a time
  function automatic void format_field(input fmt_item_t it);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  sign_ch;
    logic [CHAR_W-1:0]  digs[$];
    logic [CHAR_W-1:0]  field_text[$];
    bit                 has_sign;
    int unsigned        base;
    int unsigned        width;
    int unsigned        prec;
    int unsigned        body;
    int unsigned        total;
    int unsigned        n;
    int                 i;
    string              tab;
    fmt_char_t          c;
    mag      = it.value;
    has_sign = 1'b0;
    sign_ch  = CH_SPACE;
    base  = (it.radix_select == RSEL_OCT) ? 8 : (it.radix_select == RSEL_HEX) ? 16 : 10;
    width = (it.min_width > FIELD_LIMIT) ? FIELD_LIMIT : it.min_width;
    prec  = (it.min_digits > FIELD_LIMIT) ? FIELD_LIMIT : it.min_digits;
    tab   = it.upper_digits ? "0123456789ABCDEF" : "0123456789abcdef";
    if (it.is_signed) begin
      if (mag[VALUE_W-1]) begin
        mag      = -mag;
        has_sign = 1'b1;
        sign_ch  = CH_MINUS;
      end else if (it.force_plus) begin
        has_sign = 1'b1;
        sign_ch  = CH_PLUS;
      end else if (it.blank_sign) begin
        has_sign = 1'b1;
        sign_ch  = CH_SPACE;
      end
    end
    do begin
      digs.push_back(tab[int'(mag % base)]);
      mag = mag / base;
    end while (mag != 0);
    while (digs.size() < prec) digs.push_back(CH_ZERO);
    body  = digs.size() + int'(has_sign);
    total = (body < width) ? width : body;
    if (!it.pad_zero && !it.left_justify) begin
      repeat (total - body) field_text.push_back(CH_SPACE);
    end
    if (has_sign) field_text.push_back(sign_ch);
    if (it.pad_zero && !it.left_justify) begin
      repeat (total - body) field_text.push_back(CH_ZERO);
    end
    for (i = digs.size() - 1; i >= 0; i--) field_text.push_back(digs[i]);
    if (it.left_justify) begin
      while (field_text.size() < total) field_text.push_back(CH_SPACE);
    end
    n = (field_text.size() > MAX_FIELD_DEF) ? MAX_FIELD_DEF : field_text.size();
    for (i = 0; i < n; i++) begin
      c.out_char = field_text[i];
      c.is_last  = (i + 1 == n);
      field_chars_q.push_back(c);
    end
  endfunction

  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic fmt_item_t make_item(input logic [VALUE_W-1:0] v, input logic sgn,
                                          input logic [RSEL_W-1:0] rsel, input logic upper,
                                          input logic zpad, input logic ljust,
                                          input logic plus, input logic blank,
                                          input logic [FIELD_W-1:0] w,
                                          input logic [FIELD_W-1:0] p);
    fmt_item_t it;
    it.value        = v;
    it.is_signed    = sgn;
    it.radix_select = rsel;
    it.upper_digits = upper;
    it.pad_zero     = zpad;
    it.left_justify = ljust;
    it.force_plus   = plus;
    it.blank_sign   = blank;
    it.min_width    = w;
    it.min_digits   = p;
    return it;
  endfunction

  function automatic fmt_item_t rand_item();
    fmt_item_t          it;
    logic [VALUE_W-1:0] small_v;
    small_v = VALUE_W'($urandom_range(0, 300));
    case ($urandom_range(0, 5))
      0:       it.value = small_v;
      1:       it.value = {$urandom, $urandom};
      2:       it.value = -small_v;
      3:       it.value = {1'b1, {(VALUE_W-1){1'b0}}} + small_v - 64'd150;
      4:       it.value = {VALUE_W{1'b1}} - small_v;
      default: it.value = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
    endcase
    it.is_signed    = 1'($urandom);
    it.radix_select = RSEL_W'($urandom_range(0, 3));
    it.upper_digits = 1'($urandom);
    it.pad_zero     = 1'($urandom);
    it.left_justify = 1'($urandom);
    it.force_plus   = 1'($urandom);
    it.blank_sign   = 1'($urandom);
    it.min_width    = ($urandom_range(0, 9) < 8) ? FIELD_W'($urandom_range(0, 24))
                                                 : FIELD_W'($urandom_range(0, 63));
    it.min_digits   = ($urandom_range(0, 9) < 8) ? FIELD_W'($urandom_range(0, 24))
                                                 : FIELD_W'($urandom_range(0, 63));
    return it;
  endfunction

  // sender: new item only once the previous one has been taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || acc_cnt == sent_cnt)) begin
      if (in_if.valid) begin
        if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
        tx_gap = idle_len(tx_quiet);
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (send_q.size() > 0 && (!send_q[0].drain || field_chars_q.size() == 0)) begin
        nxt = send_q.pop_front();
        in_if.value        <= nxt.item.value;
        in_if.is_signed    <= nxt.item.is_signed;
        in_if.radix_select <= nxt.item.radix_select;
        in_if.upper_digits <= nxt.item.upper_digits;
        in_if.pad_zero     <= nxt.item.pad_zero;
        in_if.left_justify <= nxt.item.left_justify;
        in_if.force_plus   <= nxt.item.force_plus;
        in_if.blank_sign   <= nxt.item.blank_sign;
        in_if.min_width    <= nxt.item.min_width;
        in_if.min_digits   <= nxt.item.min_digits;
        in_if.valid        <= 1'b1;
        sent_cnt++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
        rx_gap = idle_len(rx_quiet);
      end
    end
  end

  // check each character transfer, predict on each accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (field_chars_q.size() == 0) begin
          $display("%0t: unexpected char expected none actual %h is_last %0b",
                   $time, out_if.out_char, out_if.is_last);
          errors++;
        end else begin
          want = field_chars_q.pop_front();
          if (out_if.out_char !== want.out_char) begin
            $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                     out_if.out_char);
            errors++;
          end
          if (out_if.is_last !== want.is_last) begin
            $display("%0t: is_last expected %0b actual %0b", $time, want.is_last,
                     out_if.is_last);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        got.value        = in_if.value;
        got.is_signed    = in_if.is_signed;
        got.radix_select = in_if.radix_select;
        got.upper_digits = in_if.upper_digits;
        got.pad_zero     = in_if.pad_zero;
        got.left_justify = in_if.left_justify;
        got.force_plus   = in_if.force_plus;
        got.blank_sign   = in_if.blank_sign;
        got.min_width    = in_if.min_width;
        got.min_digits   = in_if.min_digits;
        format_field(got);
        acc_cnt <= acc_cnt + 1;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    send_t s;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.value        = '0;
    in_if.is_signed    = 1'b0;
    in_if.radix_select = RADIX_DEC;
    in_if.upper_digits = 1'b0;
    in_if.pad_zero     = 1'b0;
    in_if.left_justify = 1'b0;
    in_if.force_plus   = 1'b0;
    in_if.blank_sign   = 1'b0;
    in_if.min_width    = '0;
    in_if.min_digits   = '0;
    out_if.ready       = 1'b0;
    sent_cnt    = 0;
    acc_cnt     = 0;
    errors      = 0;
    idle_cycles = 0;
    tx_gap      = 0;
    rx_gap      = 0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    s.drain = 1'b0;
    s.item = make_item(64'd0, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item({VALUE_W{1'b1}}, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item({VALUE_W{1'b1}}, 0, RADIX_OCT, 0, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item(64'hFEDC_BA98_7654_3210, 0, RADIX_HEX, 1, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item(64'hFEDC_BA98_7654_3210, 0, RADIX_HEX, 0, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    // most negative value
    s.item = make_item(64'h8000_0000_0000_0000, 1, RADIX_DEC, 0, 0, 0, 1, 1, 0, 0);
    send_q.push_back(s);
    s.item = make_item({VALUE_W{1'b1}}, 1, RADIX_HEX, 1, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item(64'd1234, 1, RADIX_OCT, 0, 0, 0, 1, 0, 0, 0);
    send_q.push_back(s);
    s.item = make_item(64'd1234, 1, RADIX_DEC, 0, 0, 0, 0, 1, 0, 0);
    send_q.push_back(s);
    s.item = make_item(64'd1234, 1, RADIX_DEC, 0, 0, 0, 1, 1, 0, 0);
    send_q.push_back(s);
    // sign flags ignored when unsigned
    s.item = make_item(64'd77, 0, RADIX_DEC, 0, 0, 0, 1, 1, 5, 0);
    send_q.push_back(s);
    s.item = make_item(64'd4321, 0, RSEL_SPARE, 0, 0, 0, 0, 0, 0, 0);
    send_q.push_back(s);
    // saturated width and precision
    s.item = make_item(-64'd5, 1, RADIX_DEC, 0, 1, 0, 0, 0, 6'd63, 6'd63);
    send_q.push_back(s);
    s.item = make_item(64'd9, 0, RADIX_DEC, 0, 0, 1, 0, 0, 6'd63, 6'd0);
    send_q.push_back(s);
    s.item = make_item(-64'd42, 1, RADIX_DEC, 0, 1, 0, 0, 0, 10, 0);
    send_q.push_back(s);
    s.item = make_item(-64'd42, 1, RADIX_DEC, 0, 1, 1, 0, 0, 10, 0);
    send_q.push_back(s);
    s.item = make_item(64'd42, 1, RADIX_HEX, 0, 0, 1, 1, 0, 12, 4);
    send_q.push_back(s);
    s.item = make_item(64'd42, 0, RADIX_OCT, 0, 1, 0, 0, 0, 12, 5);
    send_q.push_back(s);
    s.item = make_item(64'd42, 1, RADIX_DEC, 0, 0, 0, 0, 1, 3, 8);
    send_q.push_back(s);
    s.item = make_item(64'd0, 1, RADIX_DEC, 0, 0, 0, 1, 0, 0, 5);
    send_q.push_back(s);
    s.item = make_item(64'd123, 1, RADIX_DEC, 0, 0, 0, 0, 0, 8, 0);
    send_q.push_back(s);
    s.item = make_item(64'h7FFF_FFFF_FFFF_FFFF, 1, RADIX_DEC, 0, 0, 0, 1, 0, 25, 0);
    send_q.push_back(s);

    for (int k = 0; k < N_RANDOM; k++) begin
      s.item  = rand_item();
      s.drain = (k % 100 == 0);
      send_q.push_back(s);
    end

    while (send_q.size() != 0 || acc_cnt != sent_cnt || field_chars_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
